// ----- rtl/skf_pkg.sv -----
// shared types and constants for the scalar kalman filter
`timescale 1ns / 1ps

package skf_pkg;

  // field and datapath widths
  localparam int SAMPLE_W = 32;
  localparam int COV_W    = 32;
  localparam int GAIN_W   = 17;
  localparam int DEN_W    = COV_W + 1;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int MUL_A_W  = DIFF_W + 1;
  localparam int MUL_B_W  = GAIN_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int OUT_W    = 88;
  localparam int CFG_IDX_W = 1;

  // gain of one in Q1.16 and the gain fraction shift
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam int GAIN_SHIFT = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Q_NOISE           = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRED  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL_E = 7'b0001000,
    S_RND_E = 7'b0010000,
    S_RND_P = 7'b0100000,
    S_FIN   = 7'b1000000
  } skf_state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic             done;
    logic [GAIN_W-1:0] quo;
  } skf_div_stat_t;

endpackage

// ----- rtl/skf_div.sv -----
// restoring divider for the gain, one quotient bit per cycle
`timescale 1ns / 1ps

module skf_div import skf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [COV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output skf_div_stat_t    stat
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [GAIN_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              first;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] trial_sub;
  logic           fits;

  // first step is unshifted (it sets the integer bit), later ones shift in a zero
  always_comb begin
    trial     = first ? {1'b0, rem} : {rem, 1'b0};
    trial_sub = trial - {1'b0, den_q};
    fits      = trial >= {1'b0, den_q};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(GAIN_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quo   <= '0;
      first <= 1'b1;
    end else if (cnt != '0) begin
      rem   <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo   <= {quo[GAIN_W-2:0], fits};
      first <= 1'b0;
    end
  end

  assign stat.done = (cnt == '0);
  assign stat.quo  = quo;

endmodule

// ----- rtl/skf_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module skf_mul import skf_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ----- rtl/scalar_kalman_filter.sv -----
// scalar kalman filter top level: sequencer, state and stream ports
`timescale 1ns / 1ps
//
// channel   direction  payload
// s_*       in         tdata[31:0] sample
// m_*       out        tdata[31:0] estimate, [48:32] gain, [80:49] covariance, [87:81] zero
// cfg_*     in         cfg_idx 0 q noise, 1 measurement_noise, cfg_data 32 bits
//
// one sample passes from accept to result through prediction, the 17-step restoring
// divider that forms the gain, the shared multiplier and rounding, and the load of
// the output register; a new sample is taken only once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle and rst is low; a result waits in
// the output register, so the next sample is taken while it is not yet read, and a
// second result holds the sequencer in its last state until the first is read.
// rst is synchronous and restores the state, configuration, filter and valid registers to their defaults.

module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SAMPLE_W-1:0]  s_tdata,   // [31:0] sample
  // estimate, gain, covariance, zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [31:0] estimate, [48:32] gain, [80:49] covariance
  // configuration write
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COV_W-1:0]     cfg_data
);

  localparam logic [COV_W-1:0] Q_RESET   = COV_W'((64'd655 << FRAC_BITS) >> 16);
  localparam logic [COV_W-1:0] ONE_RESET = COV_W'(64'd1 << FRAC_BITS);
  localparam int RND_W = MUL_P_W - GAIN_SHIFT;

  skf_state_t state;

  logic [COV_W-1:0]           q_noise;
  logic [COV_W-1:0]           measurement_noise;
  logic [SAMPLE_W-1:0]        estimate_reg;
  logic [COV_W-1:0]           error_covariance;

  logic [SAMPLE_W-1:0]        sample_q;
  logic [COV_W-1:0]           pn_q;
  logic [DEN_W-1:0]           den_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic [GAIN_W-1:0]          gain_q;
  logic signed [RND_W-1:0]    corr_q;

  logic [COV_W:0]             pq_sum;
  logic [COV_W-1:0]           pn;
  logic [DEN_W-1:0]           den;

  logic                       div_start;
  skf_div_stat_t              div_stat;

  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;

  logic signed [MUL_P_W-1:0]  rnd_sum;
  logic signed [RND_W:0]      est_sum;
  logic [SAMPLE_W-1:0]        est_new;
  logic [RND_W-1:0]           cov_wide;
  logic [COV_W-1:0]           cov_new;
  logic                       out_free;

  // predicted covariance, saturating, and the gain denominator
  always_comb begin
    pq_sum = {1'b0, error_covariance} + {1'b0, q_noise};
    pn     = pq_sum[COV_W] ? '1 : pq_sum[COV_W-1:0];
    den    = {1'b0, pn_q} + {1'b0, measurement_noise};
  end

  assign s_tready  = (state == S_IDLE) && !rst;
  assign div_start = (state == S_PRED);
  assign out_free  = !m_tvalid || m_tready;

  // shared multiplier operands: gain times innovation, then covariance times one minus gain
  always_comb begin
    mul_en = 1'b0;
    mul_a  = {{(MUL_A_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
    mul_b  = {1'b0, gain_q};
    case (state)
      S_MUL_E: begin
        mul_en = 1'b1;
      end
      S_RND_E: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_A_W-COV_W){1'b0}}, pn_q};
        mul_b  = {1'b0, GAIN_ONE - gain_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // round to nearest, ties away from zero, then drop the 16 gain bits
  always_comb begin
    rnd_sum = mul_p + (mul_p[MUL_P_W-1] ? MUL_P_W'(32767) : MUL_P_W'(32768));
  end

  // estimate and covariance updates with saturation
  always_comb begin
    est_sum = {{(RND_W+1-SAMPLE_W){estimate_reg[SAMPLE_W-1]}}, estimate_reg}
            + {corr_q[RND_W-1], corr_q};
    if (!est_sum[RND_W] && (est_sum[RND_W-1:SAMPLE_W-1] != '0)) begin
      est_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (est_sum[RND_W] && (est_sum[RND_W-1:SAMPLE_W-1] != '1)) begin
      est_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      est_new = est_sum[SAMPLE_W-1:0];
    end
    cov_wide = rnd_sum[MUL_P_W-1:GAIN_SHIFT];
    cov_new  = (cov_wide[RND_W-1:COV_W] != '0) ? '1 : cov_wide[COV_W-1:0];
  end

  skf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pn_q),
    .den   (den),
    .stat  (div_stat)
  );

  skf_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise           <= Q_RESET;
      measurement_noise <= ONE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_Q_NOISE:           q_noise           <= cfg_data;
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      estimate_reg     <= '0;
      error_covariance <= ONE_RESET;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_PRED;
          end
        end
        S_PRED: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_MUL_E;
          end
        end
        S_MUL_E: begin
          state <= S_RND_E;
        end
        S_RND_E: begin
          state <= S_RND_P;
        end
        S_RND_P: begin
          estimate_reg     <= est_new;
          error_covariance <= cov_new;
          state            <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_q <= s_tdata;
      pn_q     <= pn;
    end
    if (state == S_PRED) begin
      den_q  <= den;
      diff_q <= $signed({sample_q[SAMPLE_W-1], sample_q})
              - $signed({estimate_reg[SAMPLE_W-1], estimate_reg});
    end
    if ((state == S_DIV) && div_stat.done) begin
      gain_q <= (den_q == '0) ? '0 : div_stat.quo;
    end
    if (state == S_RND_E) begin
      corr_q <= rnd_sum[MUL_P_W-1:GAIN_SHIFT];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      m_tdata <= {{(OUT_W-SAMPLE_W-GAIN_W-COV_W){1'b0}},
                  error_covariance, gain_q, estimate_reg};
    end
  end

endmodule

// ----- rtl/skf_chk.sv -----
// port-level checks for the scalar kalman filter, bound to the top level
`timescale 1ns / 1ps

module skf_chk import skf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a request keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted request");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:32] <= GAIN_ONE))
    else $error("gain above one");

  // a gain of one leaves no covariance
  a_full_gain_cov: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[48:32] == GAIN_ONE)) |-> (m_tdata[80:49] == '0))
    else $error("covariance not zero at full gain");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_chk u_skf_chk (.*);
